// File: rtl/u16u8_pkg.sv
package u16u8_pkg;

    localparam int unsigned QueueDepth = 2;

    localparam logic [20:0] MaxOneByte   = 21'h00007f;
    localparam logic [20:0] MaxTwoByte   = 21'h0007ff;
    localparam logic [20:0] MaxThreeByte = 21'h00ffff;
    localparam logic [20:0] SuppBase     = 21'h010000;

    localparam logic [5:0] HighTag = 6'b110110;
    localparam logic [5:0] LowTag  = 6'b110111;

    localparam logic [2:0] Lead2 = 3'b110;
    localparam logic [3:0] Lead3 = 4'b1110;
    localparam logic [4:0] Lead4 = 5'b11110;
    localparam logic [1:0] Cont  = 2'b10;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            is_end;
        logic            status;
    } t_job;

    function automatic t_job f_encode(input logic [20:0] s);
        t_job j;
        j = '0;
        if (s <= MaxOneByte) begin
            j.bytes[0] = s[7:0];
            j.last_idx = 2'd0;
        end else if (s <= MaxTwoByte) begin
            j.bytes[0] = {Lead2, s[10:6]};
            j.bytes[1] = {Cont, s[5:0]};
            j.last_idx = 2'd1;
        end else if (s <= MaxThreeByte) begin
            j.bytes[0] = {Lead3, s[15:12]};
            j.bytes[1] = {Cont, s[11:6]};
            j.bytes[2] = {Cont, s[5:0]};
            j.last_idx = 2'd2;
        end else begin
            j.bytes[0] = {Lead4, s[20:18]};
            j.bytes[1] = {Cont, s[17:12]};
            j.bytes[2] = {Cont, s[11:6]};
            j.bytes[3] = {Cont, s[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

endpackage

// File: rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. One code unit is taken per cycle while o_stall is low;
// each scalar leaves as one to four bytes, one byte per cycle while i_stall is low,
// with o_run_last on the final byte of the run. A zero unit closes the string with a
// single zero byte that carries o_string_end and o_status (1 = bad surrogate sequence;
// earlier bytes of that string are then to be discarded, and later ones are suppressed).
// A unit passes through the job queue and the output byte register on its way out.
// Sustained input rate is one unit per cycle for ASCII while i_stall is low; for longer
// runs it is set by the byte serialiser, and a two-entry job queue between the classifier
// and the serialiser absorbs the difference before o_stall rises.
module utf16_to_utf8_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_string_end,
    output logic        o_status
);
    import u16u8_pkg::*;

    logic push, pop, full, empty;
    t_job job, head;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_code_unit (i_code_unit),
        .i_full      (full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (job)
    );

    u16u8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end),
        .o_status     (o_status)
    );

endmodule

// File: rtl/u16u8_front.sv
module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_code_unit,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output u16u8_pkg::t_job   o_job
);
    import u16u8_pkg::*;

    logic [9:0] r_held_bits, n_held_bits;
    logic       r_held_valid, n_held_valid;
    logic       r_failed, n_failed;
    logic       accept, is_zero, is_high, is_low;
    logic [20:0] supp;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign is_zero = (i_code_unit == 16'h0000);
    assign is_high = (i_code_unit[15:10] == HighTag);
    assign is_low  = (i_code_unit[15:10] == LowTag);
    assign supp    = SuppBase + {1'b0, r_held_bits, i_code_unit[9:0]};

    always_comb begin
        n_held_bits  = r_held_bits;
        n_held_valid = r_held_valid;
        n_failed     = r_failed;
        o_push       = 1'b0;
        o_job        = '0;
        if (accept) begin
            if (is_zero) begin
                o_push       = 1'b1;
                o_job.is_end = 1'b1;
                o_job.status = r_failed || r_held_valid;
                n_held_bits  = '0;
                n_held_valid = 1'b0;
                n_failed     = 1'b0;
            end else if (r_failed) begin
                n_held_bits  = '0;
                n_held_valid = 1'b0;
            end else if (r_held_valid) begin
                n_held_bits  = '0;
                n_held_valid = 1'b0;
                if (!is_low) begin
                    n_failed = 1'b1;
                end else begin
                    o_push = 1'b1;
                    o_job  = f_encode(supp);
                end
            end else if (is_high) begin
                n_held_bits  = i_code_unit[9:0];
                n_held_valid = 1'b1;
            end else if (is_low) begin
                n_failed = 1'b1;
            end else begin
                o_push = 1'b1;
                o_job  = f_encode({5'd0, i_code_unit});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits  <= '0;
            r_held_valid <= 1'b0;
            r_failed     <= 1'b0;
        end else begin
            r_held_bits  <= n_held_bits;
            r_held_valid <= n_held_valid;
            r_failed     <= n_failed;
        end
    end

endmodule

// File: rtl/u16u8_fifo.sv
module u16u8_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u16u8_pkg::t_job   i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output u16u8_pkg::t_job   o_head
);
    import u16u8_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);

    t_job                 r_mem [QueueDepth];
    logic [PtrW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [PtrW:0]        r_count, n_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == (PtrW + 1)'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/u16u8_back.sv
module u16u8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  u16u8_pkg::t_job   i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_string_end,
    output logic              o_status
);
    import u16u8_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_last, r_end, r_status;
    logic       load, at_last;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && at_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = at_last ? 2'd0 : r_idx + 2'd1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= i_head.is_end ? 8'h00 : i_head.bytes[r_idx];
            r_last   <= at_last;
            r_end    <= i_head.is_end;
            r_status <= i_head.is_end && i_head.status;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_last;
    assign o_string_end = r_end;
    assign o_status     = r_status;

endmodule
